### hdl/differential_drive_mixer_top_defines.svh
// ----------------------------------------------------------------------------
// differential drive mixer assertion macros
// shared concurrent assertion forms for the mixer checker
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_MIXER_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_TOP_DEFINES_SVH

// property checked on every edge outside reset
`define DDM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge including reset
`define DDM_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// widths, field positions and helpers of the differential drive mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;
   localparam int CMD_W     = 8;
   localparam int MAG_W     = 8;
   localparam int SUM_W     = MAG_W + 1;
   localparam int Q_W       = 7;
   localparam int MIX_W     = 10;
   localparam int MIX_LIMIT = 127;
   localparam int DUTY_MAX  = 254;

   // request tdata positions
   localparam int REQ_TURN_LO  = 0;
   localparam int REQ_DRIVE_LO = 8;
   localparam int REQ_LSTOP    = 16;
   localparam int REQ_RSTOP    = 17;

   // response tdata positions
   localparam int RSP_LFWD    = 0;
   localparam int RSP_LBWD    = 1;
   localparam int RSP_LDUTY_LO = 2;
   localparam int RSP_RFWD    = 10;
   localparam int RSP_RBWD    = 11;
   localparam int RSP_RDUTY_LO = 12;

   typedef struct packed {
      logic       fwd;
      logic       bwd;
      logic [7:0] duty;
   } motor_out_type;

   function automatic motor_out_type motor_drive(input logic signed [MIX_W-1:0] mix,
                                                 input logic stop);
      motor_out_type           res;
      logic [MIX_W-1:0]        mag;
      mag = mix[MIX_W-1] ? MIX_W'(-mix) : MIX_W'(mix);
      res.fwd  = 1'b0;
      res.bwd  = 1'b0;
      res.duty = 8'd0;
      if (!stop && (mix != '0)) begin
         res.fwd  = ~mix[MIX_W-1];
         res.bwd  = mix[MIX_W-1];
         res.duty = mag[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### hdl/differential_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// differential drive mixer
// slews turn and drive commands, limits their magnitude sum by a bit serial
// restoring division and mixes them into left and right bridge commands
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (lsb first)
//  req     | in        | turn_command, drive_command, left_stop, right_stop
//  rsp     | out       | left fwd, left bwd, left duty, right fwd, right bwd, right duty
//
//  a transfer runs idle, prep, div, fin when the magnitude sum exceeds 127, else idle, prep, fin
//  the divider produces one quotient bit per cycle for both channels (7 steps)
//  reset is synchronous and clears the slewed values and the output valid
//  a new request is taken as soon as the mix reaches the output register
//  a stalled response holds the mixer in its last cycle until the slot frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_mixer_top
   import ddm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // turn[7:0] drive[15:8] lstop[16] rstop[17]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata   // lfwd lbwd lduty[9:2] rfwd rbwd rduty[19:12]
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic signed [CMD_W-1:0] slew_turn_ff, slew_turn_in;
   logic signed [CMD_W-1:0] slew_drive_ff, slew_drive_in;
   logic                    lstop_ff, lstop_in, rstop_ff, rstop_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [SUM_W-1:0]        div_ff, div_in;
   logic [SUM_W-1:0]        rem_t_ff, rem_t_in, rem_d_ff, rem_d_in;
   logic [Q_W-1:0]          num_t_ff, num_t_in, num_d_ff, num_d_in;
   logic [Q_W-1:0]          q_t_ff, q_t_in, q_d_ff, q_d_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic signed [CMD_W-1:0] turn_cmd, drive_cmd;
   logic [MAG_W-1:0]        ta, da;
   logic [SUM_W-1:0]        sum;
   logic [2*Q_W:0]          prod_t, prod_d;
   logic [SUM_W:0]          trial_t, trial_d;
   logic                    qbit_t, qbit_d;
   logic signed [MIX_W-1:0] t_mix, d_mix, mix_l, mix_r;
   logic                    out_free;
   motor_out_type           mot_l, mot_r;

   assign turn_cmd  = req_tdata[REQ_TURN_LO +: CMD_W];
   assign drive_cmd = req_tdata[REQ_DRIVE_LO +: CMD_W];

   assign ta  = slew_turn_ff[CMD_W-1]  ? MAG_W'(-slew_turn_ff)  : MAG_W'(slew_turn_ff);
   assign da  = slew_drive_ff[CMD_W-1] ? MAG_W'(-slew_drive_ff) : MAG_W'(slew_drive_ff);
   assign sum = {1'b0, ta} + {1'b0, da};

   // magnitude times 127 as shift and subtract
   assign prod_t = {ta, 7'd0} - {7'd0, ta};
   assign prod_d = {da, 7'd0} - {7'd0, da};

   assign trial_t = {rem_t_ff, num_t_ff[Q_W-1]};
   assign trial_d = {rem_d_ff, num_d_ff[Q_W-1]};
   assign qbit_t  = trial_t >= {1'b0, div_ff};
   assign qbit_d  = trial_d >= {1'b0, div_ff};

   assign t_mix = slew_turn_ff[CMD_W-1]  ? -$signed({2'b00, q_t_ff, 1'b0})
                                         :  $signed({2'b00, q_t_ff, 1'b0});
   assign d_mix = slew_drive_ff[CMD_W-1] ? -$signed({2'b00, q_d_ff, 1'b0})
                                         :  $signed({2'b00, q_d_ff, 1'b0});
   assign mix_l = d_mix + t_mix;
   assign mix_r = d_mix - t_mix;
   assign mot_l = motor_drive(mix_l, lstop_ff);
   assign mot_r = motor_drive(mix_r, rstop_ff);

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      slew_turn_in  = slew_turn_ff;
      slew_drive_in = slew_drive_ff;
      lstop_in      = lstop_ff;
      rstop_in      = rstop_ff;
      cnt_in        = cnt_ff;
      div_in        = div_ff;
      rem_t_in      = rem_t_ff;
      rem_d_in      = rem_d_ff;
      num_t_in      = num_t_ff;
      num_d_in      = num_d_ff;
      q_t_in        = q_t_ff;
      q_d_in        = q_d_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (turn_cmd > slew_turn_ff)
                  slew_turn_in = slew_turn_ff + 8'sd1;
               else if (turn_cmd < slew_turn_ff)
                  slew_turn_in = slew_turn_ff - 8'sd1;
               if (drive_cmd > slew_drive_ff)
                  slew_drive_in = slew_drive_ff + 8'sd1;
               else if (drive_cmd < slew_drive_ff)
                  slew_drive_in = slew_drive_ff - 8'sd1;
               lstop_in = req_tdata[REQ_LSTOP];
               rstop_in = req_tdata[REQ_RSTOP];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (sum > SUM_W'(MIX_LIMIT)) begin
               div_in   = sum;
               rem_t_in = {2'b00, prod_t[2*Q_W-1:Q_W]};
               rem_d_in = {2'b00, prod_d[2*Q_W-1:Q_W]};
               num_t_in = prod_t[Q_W-1:0];
               num_d_in = prod_d[Q_W-1:0];
               cnt_in   = 3'd0;
               state_in = ST_DIV;
            end else begin
               q_t_in   = ta[Q_W-1:0];
               q_d_in   = da[Q_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            rem_t_in = qbit_t ? SUM_W'(trial_t - {1'b0, div_ff}) : trial_t[SUM_W-1:0];
            rem_d_in = qbit_d ? SUM_W'(trial_d - {1'b0, div_ff}) : trial_d[SUM_W-1:0];
            num_t_in = {num_t_ff[Q_W-2:0], 1'b0};
            num_d_in = {num_d_ff[Q_W-2:0], 1'b0};
            q_t_in   = {q_t_ff[Q_W-2:0], qbit_t};
            q_d_in   = {q_d_ff[Q_W-2:0], qbit_d};
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'(Q_W - 1))
               state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RSP_LFWD]              = mot_l.fwd;
               rsp_data_in[RSP_LBWD]              = mot_l.bwd;
               rsp_data_in[RSP_LDUTY_LO +: 8]     = mot_l.duty;
               rsp_data_in[RSP_RFWD]              = mot_r.fwd;
               rsp_data_in[RSP_RBWD]              = mot_r.bwd;
               rsp_data_in[RSP_RDUTY_LO +: 8]     = mot_r.duty;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slew_turn_ff  <= '0;
         slew_drive_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slew_turn_ff  <= slew_turn_in;
         slew_drive_ff <= slew_drive_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lstop_ff    <= lstop_in;
      rstop_ff    <= rstop_in;
      cnt_ff      <= cnt_in;
      div_ff      <= div_in;
      rem_t_ff    <= rem_t_in;
      rem_d_ff    <= rem_d_in;
      num_t_ff    <= num_t_in;
      num_d_ff    <= num_d_in;
      q_t_ff      <= q_t_in;
      q_d_ff      <= q_d_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### hdl/ddm_checker.sv
// ----------------------------------------------------------------------------
// ddm_checker
// port level checks of the differential drive mixer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "differential_drive_mixer_top_defines.svh"

module ddm_checker
   import ddm_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [REQ_W-1:0] req_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   logic       lf, lb, rf, rb;
   logic [7:0] ld, rd;
   logic       req_seen;

   assign lf = rsp_tdata[RSP_LFWD];
   assign lb = rsp_tdata[RSP_LBWD];
   assign ld = rsp_tdata[RSP_LDUTY_LO +: 8];
   assign rf = rsp_tdata[RSP_RFWD];
   assign rb = rsp_tdata[RSP_RBWD];
   assign rd = rsp_tdata[RSP_RDUTY_LO +: 8];
   assign req_seen = req_tvalid & req_tready & (req_tdata != '1);

   `DDM_ASSERT(a_left_dir, clock, reset, rsp_tvalid |-> !(lf && lb) && ((ld != 8'd0) == (lf || lb)), "left direction and duty disagree")
   `DDM_ASSERT(a_right_dir, clock, reset, rsp_tvalid |-> !(rf && rb) && ((rd != 8'd0) == (rf || rb)), "right direction and duty disagree")
   `DDM_ASSERT(a_duty_range, clock, reset, rsp_tvalid |-> (ld <= 8'(DUTY_MAX)) && (rd <= 8'(DUTY_MAX)), "duty above limit")
   `DDM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `DDM_ASSERT_ALL(a_reset_clear, clock, $past(reset) |-> !rsp_tvalid || $past(req_seen), "response valid after reset")

endmodule

bind differential_drive_mixer_top ddm_checker u_ddm_checker (.*);

`default_nettype wire

### test/differential_drive_mixer_top_tb.sv
// ----------------------------------------------------------------------------
// differential drive mixer testbench
// drives turn and drive commands with stop flags through the request stream,
// tracks the slewed commands and the magnitude limit in a local model of the
// mixer and checks every left and right bridge response in order, with random
// gaps on both streams and one long response back-pressure stretch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_mixer_top_tb;
   import ddm_pkg::*;

   localparam int ITEM_TARGET = 1650;
   localparam int TAIL_ITEMS  = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 40;
   localparam int MIX_GAIN    = 2;

   localparam motor_out_type MOTOR_OFF = '0;
   localparam motor_out_type FWD_4     = '{fwd: 1'b1, bwd: 1'b0, duty: 8'd4};
   localparam motor_out_type BWD_4     = '{fwd: 1'b0, bwd: 1'b1, duty: 8'd4};

   typedef struct packed {
      motor_out_type left;
      motor_out_type right;
   } bridge_pair_type;

   typedef struct {
      logic [7:0]    turn;
      logic [7:0]    drive;
      logic          lstop;
      logic          rstop;
      bit            typed;
      motor_out_type left;
      motor_out_type right;
   } stim_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tready = 1'b0;
   logic             req_tready;
   logic             rsp_tvalid;
   logic [RSP_W-1:0] rsp_tdata;

   bridge_pair_type  bridge_expected[$];
   int               slewed_turn  = 0;
   int               slewed_drive = 0;
   int               items_sent   = 0;
   int               mismatches   = 0;
   bit               tail_phase   = 1'b0;
   bit               quiet        = 1'b0;
   bit               hold_done    = 1'b0;

   stim_row_type directed_rows [16] = '{
      '{8'h00, 8'h00, 1'b0, 1'b0, 1'b1, MOTOR_OFF, MOTOR_OFF},
      '{8'h7F, 8'h7F, 1'b0, 1'b0, 1'b1, FWD_4,     MOTOR_OFF},
      '{8'h80, 8'h80, 1'b1, 1'b1, 1'b1, MOTOR_OFF, MOTOR_OFF},
      '{8'h80, 8'h80, 1'b0, 1'b0, 1'b1, BWD_4,     MOTOR_OFF},
      '{8'h7F, 8'h80, 1'b0, 1'b0, 1'b1, BWD_4,     BWD_4},
      '{8'h7F, 8'h80, 1'b1, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h7F, 8'h80, 1'b0, 1'b1, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'hFF, 8'h01, 1'b0, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h01, 8'hFF, 1'b0, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h00, 8'h7F, 1'b0, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h80, 8'h00, 1'b0, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h7F, 8'h7F, 1'b1, 1'b1, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h55, 8'hAA, 1'b0, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'hAA, 8'h55, 1'b0, 1'b1, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h7F, 8'h00, 1'b0, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF},
      '{8'h00, 8'h80, 1'b1, 1'b0, 1'b0, MOTOR_OFF, MOTOR_OFF}
   };

   differential_drive_mixer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic motor_out_type bridge_for(input int mix, input logic stop);
      motor_out_type res;
      res = MOTOR_OFF;
      if (!stop && mix != 0) begin
         res.fwd  = (mix > 0);
         res.bwd  = (mix < 0);
         res.duty = 8'((mix < 0) ? -mix : mix);
      end
      return res;
   endfunction

   // advances the slewed commands and returns the limited, mixed bridge outputs
   function automatic bridge_pair_type mix_tick(input stim_row_type row);
      bridge_pair_type res;
      int              turn_cmd;
      int              drive_cmd;
      int              turn_mag;
      int              drive_mag;
      int              total;
      int              t;
      int              d;
      turn_cmd  = int'($signed(row.turn));
      drive_cmd = int'($signed(row.drive));
      if (turn_cmd > slewed_turn) slewed_turn++;
      else if (turn_cmd < slewed_turn) slewed_turn--;
      if (drive_cmd > slewed_drive) slewed_drive++;
      else if (drive_cmd < slewed_drive) slewed_drive--;
      turn_mag  = (slewed_turn < 0) ? -slewed_turn : slewed_turn;
      drive_mag = (slewed_drive < 0) ? -slewed_drive : slewed_drive;
      total     = turn_mag + drive_mag;
      if (total > MIX_LIMIT) begin
         d = (drive_mag * MIX_LIMIT) / total;
         t = (turn_mag * MIX_LIMIT) / total;
      end else begin
         d = drive_mag;
         t = turn_mag;
      end
      d = d * MIX_GAIN;
      t = t * MIX_GAIN;
      if (slewed_drive < 0) d = -d;
      if (slewed_turn < 0) t = -t;
      res.left  = bridge_for(d + t, row.lstop);
      res.right = bridge_for(d - t, row.rstop);
      return res;
   endfunction

   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 5))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic issue(input stim_row_type row);
      bridge_pair_type want;
      logic [REQ_W-1:0] word;
      tail_phase = (items_sent >= ITEM_TARGET - TAIL_ITEMS);
      word = '0;
      word[REQ_TURN_LO +: CMD_W]  = row.turn;
      word[REQ_DRIVE_LO +: CMD_W] = row.drive;
      word[REQ_LSTOP]             = row.lstop;
      word[REQ_RSTOP]             = row.rstop;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      want = mix_tick(row);
      if (row.typed) begin
         want.left  = row.left;
         want.right = row.right;
      end
      bridge_expected.push_back(want);
      items_sent++;
      if (!tail_phase && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      stim_row_type row;
      int           span;
      int           k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) issue(directed_rows[i]);
      row.typed = 1'b0;
      row.left  = MOTOR_OFF;
      row.right = MOTOR_OFF;
      while (items_sent < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            // held commands let the slewed values reach the limits
            row.turn  = pick_command();
            row.drive = pick_command();
            span = $urandom_range(1, 260);
            for (k = 0; k < span && items_sent < ITEM_TARGET; k++) begin
               row.lstop = ($urandom_range(0, 15) == 0);
               row.rstop = ($urandom_range(0, 15) == 0);
               issue(row);
            end
         end else begin
            span = $urandom_range(1, 20);
            for (k = 0; k < span && items_sent < ITEM_TARGET; k++) begin
               row.turn  = 8'($urandom);
               row.drive = 8'($urandom);
               row.lstop = 1'($urandom);
               row.rstop = 1'($urandom);
               issue(row);
            end
         end
      end
      req_tvalid <= 1'b0;
      while (bridge_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : rsp_pacing
      int stretch;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= 120) begin
            // long back-pressure so the mixer fills and stalls the request side
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            for (stretch = 0; stretch < HOLD_CYCLES; stretch++) @(posedge clock);
         end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      bridge_pair_type got;
      bridge_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left  = {rsp_tdata[RSP_LFWD], rsp_tdata[RSP_LBWD], rsp_tdata[RSP_LDUTY_LO +: 8]};
         got.right = {rsp_tdata[RSP_RFWD], rsp_tdata[RSP_RBWD], rsp_tdata[RSP_RDUTY_LO +: 8]};
         if (bridge_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: got L %b%b/%0d R %b%b/%0d",
                        got.left.fwd, got.left.bwd, got.left.duty,
                        got.right.fwd, got.right.bwd, got.right.duty);
         end else begin
            want = bridge_expected.pop_front();
            if (got.left.fwd !== want.left.fwd || got.left.bwd !== want.left.bwd ||
                got.left.duty !== want.left.duty || got.right.fwd !== want.right.fwd ||
                got.right.bwd !== want.right.bwd || got.right.duty !== want.right.duty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp L %b%b/%0d R %b%b/%0d, got L %b%b/%0d R %b%b/%0d",
                           want.left.fwd, want.left.bwd, want.left.duty,
                           want.right.fwd, want.right.bwd, want.right.duty,
                           got.left.fwd, got.left.bwd, got.left.duty,
                           got.right.fwd, got.right.bwd, got.right.duty);
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/ddm_pkg.sv
hdl/differential_drive_mixer_top.sv
hdl/ddm_checker.sv
test/differential_drive_mixer_top_tb.sv
